// ----- hdl/ltcr_pkg.sv -----
package ltcr_pkg;

    // Input command codes
    localparam logic [1:0] CMD_LEVEL = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_SYNC  = 2'd2;

    // Configuration register indexes
    localparam logic REG_WINDOW_TICKS = 1'b0;
    localparam logic REG_NUM_SYMBOL   = 1'b1;

    localparam int CFG_DATA_W   = 16;
    localparam int TIMER_W      = 16;
    localparam int VALUE_W      = 8;

    localparam logic [TIMER_W-1:0] WINDOW_TICKS_RESET = 16'd1000;

    typedef struct packed {
        logic [1:0] command;
        logic       num_level;
        logic       caps_level;
        logic       tx_busy;
    } in_item_t;

endpackage

// ----- hdl/lock_toggle_command_receiver_unit.sv -----
// Lock-toggle command receiver.
//
// Input channel (in_valid/in_ready) carries one item per transfer: a level
// update, a timer tick or a level sync, with the current num and caps lock
// levels and the transmitter busy flag. Two toggles of one lock shift one bit
// into the command word, MSB first. Output channel (out_valid/out_ready)
// returns exactly one result per item: word_ready with word_value when the
// item completed the word (once per window), and the window state.
//
// An input transfer loads the input register, then the decode step writes
// the result register, which drives out_valid. One item is taken every
// cycle unless the result register stalls; the decode state update sets
// that rate. A full result register stalls the decode step, and the input
// register then holds its item; in_ready drops only when both are occupied.
//
// Reset clears the decode state, empties both stages and loads the
// configuration defaults (window of 1000 ticks, num pair encodes 0).
// Configuration writes on cfg_write take effect on the next item; a window
// already open keeps the length it was opened with.
module lock_toggle_command_receiver_unit
    import ltcr_pkg::*;
#(
    parameter int WORD_BITS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            command,
    input  logic                  num_level,
    input  logic                  caps_level,
    input  logic                  tx_busy,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  word_ready,
    output logic [VALUE_W-1:0]    word_value,
    output logic                  window_open
);

    localparam int BT_W = $clog2(WORD_BITS + 1);
    localparam logic [BT_W-1:0] FULL_COUNT = BT_W'(WORD_BITS);

    // Configuration
    logic [TIMER_W-1:0]   window_ticks_reg;
    logic                 num_symbol_reg;

    // Input stage
    logic                 in_valid_reg;
    in_item_t             item_reg;
    logic                 advance;

    // Decode state
    logic                 last_num_reg, last_num_next;
    logic                 last_caps_reg, last_caps_next;
    logic                 in_window_reg, in_window_next;
    logic [TIMER_W-1:0]   timer_reg, timer_next;
    logic                 num_half_reg, num_half_next;
    logic                 caps_half_reg, caps_half_next;
    logic [BT_W-1:0]      bits_taken_reg, bits_taken_next;
    logic [WORD_BITS-1:0] shift_word_reg, shift_word_next;
    logic                 still_valid_reg, still_valid_next;
    logic                 reported_reg, reported_next;

    // Result stage
    logic                 out_valid_reg;
    logic                 word_ready_reg, word_ready_next;
    logic [VALUE_W-1:0]   word_value_reg, word_value_next;
    logic                 window_open_reg;

    logic                 num_chg;
    logic                 caps_chg;
    logic [WORD_BITS+VALUE_W-1:0] word_ext;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign num_chg  = item_reg.num_level != last_num_reg;
    assign caps_chg = item_reg.caps_level != last_caps_reg;
    assign word_ext = {{VALUE_W{1'b0}}, shift_word_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_ticks_reg <= WINDOW_TICKS_RESET;
            num_symbol_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_WINDOW_TICKS: window_ticks_reg <= cfg_data[TIMER_W-1:0];
                REG_NUM_SYMBOL:   num_symbol_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= '{command, num_level, caps_level, tx_busy};
    end

    // Decode step
    always_comb
    begin
        last_num_next    = last_num_reg;
        last_caps_next   = last_caps_reg;
        in_window_next   = in_window_reg;
        timer_next       = timer_reg;
        num_half_next    = num_half_reg;
        caps_half_next   = caps_half_reg;
        bits_taken_next  = bits_taken_reg;
        shift_word_next  = shift_word_reg;
        still_valid_next = still_valid_reg;
        reported_next    = reported_reg;
        word_ready_next  = 1'b0;

        unique case (item_reg.command)
            CMD_LEVEL:
            begin
                if (!item_reg.tx_busy && (num_chg || caps_chg))
                begin
                    if (!in_window_reg)
                    begin
                        in_window_next = 1'b1;
                        timer_next     = window_ticks_reg;
                    end
                    if (still_valid_reg)
                    begin
                        if (num_chg)
                        begin
                            if (!caps_chg && !caps_half_reg && bits_taken_reg < FULL_COUNT)
                            begin
                                // second toggle of a pair completes the bit
                                if (num_half_reg)
                                begin
                                    shift_word_next = (shift_word_reg << 1)
                                                    | WORD_BITS'(num_symbol_reg);
                                    bits_taken_next = bits_taken_reg + 1'b1;
                                    num_half_next   = 1'b0;
                                end
                                else
                                    num_half_next = 1'b1;
                            end
                            else
                                still_valid_next = 1'b0;
                        end
                        if (caps_chg)
                        begin
                            if (!num_chg && !num_half_reg && bits_taken_reg < FULL_COUNT)
                            begin
                                if (caps_half_reg)
                                begin
                                    shift_word_next = (shift_word_reg << 1)
                                                    | {{(WORD_BITS-1){1'b0}},
                                                       ~num_symbol_reg};
                                    bits_taken_next = bits_taken_reg + 1'b1;
                                    caps_half_next  = 1'b0;
                                end
                                else
                                    caps_half_next = 1'b1;
                            end
                            else
                                still_valid_next = 1'b0;
                        end
                    end
                    // full word: report once, cancel any further toggles
                    if (bits_taken_next == FULL_COUNT)
                    begin
                        if (!reported_reg)
                        begin
                            word_ready_next = 1'b1;
                            reported_next   = 1'b1;
                        end
                        still_valid_next = 1'b0;
                    end
                end
                last_num_next  = item_reg.num_level;
                last_caps_next = item_reg.caps_level;
            end
            CMD_TICK:
            begin
                if (in_window_reg)
                begin
                    if (timer_reg <= TIMER_W'(1))
                    begin
                        // close the window and drop the partial word
                        in_window_next   = 1'b0;
                        timer_next       = '0;
                        num_half_next    = 1'b0;
                        caps_half_next   = 1'b0;
                        bits_taken_next  = '0;
                        shift_word_next  = '0;
                        still_valid_next = 1'b1;
                        reported_next    = 1'b0;
                    end
                    else
                        timer_next = timer_reg - 1'b1;
                end
            end
            CMD_SYNC:
            begin
                last_num_next  = item_reg.num_level;
                last_caps_next = item_reg.caps_level;
            end
            default: ;
        endcase

        word_value_next = word_ready_next ? word_ext[VALUE_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_num_reg    <= 1'b0;
            last_caps_reg   <= 1'b0;
            in_window_reg   <= 1'b0;
            timer_reg       <= '0;
            num_half_reg    <= 1'b0;
            caps_half_reg   <= 1'b0;
            bits_taken_reg  <= '0;
            shift_word_reg  <= '0;
            still_valid_reg <= 1'b1;
            reported_reg    <= 1'b0;
        end
        else if (advance)
        begin
            last_num_reg    <= last_num_next;
            last_caps_reg   <= last_caps_next;
            in_window_reg   <= in_window_next;
            timer_reg       <= timer_next;
            num_half_reg    <= num_half_next;
            caps_half_reg   <= caps_half_next;
            bits_taken_reg  <= bits_taken_next;
            shift_word_reg  <= shift_word_next;
            still_valid_reg <= still_valid_next;
            reported_reg    <= reported_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            word_ready_reg  <= word_ready_next;
            word_value_reg  <= word_value_next;
            window_open_reg <= in_window_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign word_ready  = word_ready_reg;
    assign word_value  = word_value_reg;
    assign window_open = window_open_reg;

endmodule
